[rtl/core/trcp_pkg.sv]
// ----------------------------------------------------------------------------
// trcp_pkg: shared types, constants and helpers for the traceparent parser
// Marker spelling, value-field offsets, status codes and hex decoding.
// ----------------------------------------------------------------------------
package trcp_pkg;

  // Default text length limit; bytes at or past this index are dropped
  localparam longint unsigned MAX_TEXT_DEF = 64'd65535;

  // "traceparent='" marker and the minimum marker-to-end distance
  localparam int MARK_LEN = 13;
  localparam int MIN_SPAN = 55 + 13;

  // Offsets inside the value, counted from the byte after the marker
  localparam int DASH_A_OFS   = 2;
  localparam int TRACE_FIRST  = 3;
  localparam int TRACE_LAST   = 34;
  localparam int DASH_B_OFS   = 35;
  localparam int PARENT_FIRST = 36;
  localparam int PARENT_LAST  = 51;
  localparam int DASH_C_OFS   = 52;
  localparam int FLAGS_FIRST  = 53;
  localparam int FLAGS_LAST   = 54;

  // Field check bits
  localparam int FV_DASH_A = 0;
  localparam int FV_TRACE  = 1;
  localparam int FV_DASH_B = 2;
  localparam int FV_PARENT = 3;
  localparam int FV_DASH_C = 4;
  localparam int FV_FLAGS  = 5;

  // Parse status codes
  localparam logic [1:0] STAT_NONE   = 2'd0;
  localparam logic [1:0] STAT_TRACE  = 2'd1;
  localparam logic [1:0] STAT_PARENT = 2'd2;
  localparam logic [1:0] STAT_ALL    = 2'd3;

  // Characters of interest
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  // One input byte as carried through the input register
  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
    logic       parameter_form;
  } trcp_item_t;

  // One result
  typedef struct packed {
    logic [1:0]  parse_status;
    logic [63:0] trace_id_high;
    logic [63:0] trace_id_low;
    logic [63:0] parent_span_id;
    logic [7:0]  sampled_flags;
  } trcp_result_t;

  // Marker character at position k
  function automatic logic [7:0] mark_char(input logic [3:0] k);
    logic [7:0] ch;
    case (k)
      4'd0:    ch = "t";
      4'd1:    ch = "r";
      4'd2:    ch = "a";
      4'd3:    ch = "c";
      4'd4:    ch = "e";
      4'd5:    ch = "p";
      4'd6:    ch = "a";
      4'd7:    ch = "r";
      4'd8:    ch = "e";
      4'd9:    ch = "n";
      4'd10:   ch = "t";
      4'd11:   ch = "=";
      4'd12:   ch = 8'h27;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Longest proper border of the first k marker characters
  function automatic logic [3:0] mark_fallback(input logic [3:0] k);
    logic [3:0] fb;
    case (k)
      4'd11:   fb = 4'd1;
      default: fb = 4'd0;
    endcase
    return fb;
  endfunction

  // Matcher step; the border chain is at most two links deep
  function automatic logic [3:0] mark_step(input logic [3:0] k_in, input logic [7:0] c);
    logic [3:0] k;
    k = (k_in >= 4'(MARK_LEN)) ? 4'd0 : k_in;
    for (int i = 0; i < 2; i++) begin
      if (k != 4'd0 && c != mark_char(k)) k = mark_fallback(k);
    end
    if (c == mark_char(k)) k = k + 4'd1;
    return k;
  endfunction

  // Hex digit decode; bit 4 set means not a hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] h;
    if (c >= "0" && c <= "9")      h = 5'(c - 8'h30);
    else if (c >= "a" && c <= "f") h = 5'(c - 8'h57);
    else if (c >= "A" && c <= "F") h = 5'(c - 8'h37);
    else                           h = 5'd16;
    return h;
  endfunction

endpackage

[rtl/core/trcp_scan.sv]
// ----------------------------------------------------------------------------
// trcp_scan: per-byte scanner state and result evaluation
// Tracks opener, closer, marker match and value fields; forms the result
// combinationally from the byte being retired and clears at the last byte.
// ----------------------------------------------------------------------------
module trcp_scan #(
  parameter longint unsigned MAX_TEXT = trcp_pkg::MAX_TEXT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  trcp_pkg::trcp_item_t  item,
  output trcp_pkg::trcp_result_t result
);
  import trcp_pkg::*;

  localparam int POS_W = $clog2(MAX_TEXT + 1);

  logic [POS_W-1:0] cnt_r, cnt_nxt;
  logic             opener_ok_r, opener_ok_nxt;
  logic             closer_found_r, closer_found_nxt;
  logic [POS_W-1:0] closer_pos_r, closer_pos_nxt;
  logic [7:0]       prev_byte_r, prev_byte_nxt;
  logic [3:0]       mark_prog_r, mark_prog_nxt;
  logic             mark_found_r, mark_found_nxt;
  logic [POS_W-1:0] mark_pos_r, mark_pos_nxt;
  logic [63:0]      trace_hi_r, trace_hi_nxt;
  logic [63:0]      trace_lo_r, trace_lo_nxt;
  logic [63:0]      parent_r, parent_nxt;
  logic [7:0]       flags_r, flags_nxt;
  logic [5:0]       fvalid_r, fvalid_nxt;

  logic             take;
  logic [7:0]       c;
  logic [4:0]       hex;
  logic [POS_W:0]   val_start;
  logic [POS_W:0]   rel;
  logic [POS_W:0]   rel_m3;
  logic [3:0]       k_new;
  logic [POS_W-1:0] end_pos;
  logic             ok;

  assign c    = item.text_byte;
  assign take = (cnt_r != POS_W'(MAX_TEXT));
  assign hex  = hex_nibble(c);
  assign val_start = {1'b0, mark_pos_r} + (POS_W+1)'(MARK_LEN);
  assign rel       = {1'b0, cnt_r} - val_start;
  assign rel_m3    = rel - (POS_W+1)'(TRACE_FIRST);
  assign k_new     = mark_step(mark_prog_r, c);

  // Byte update
  always_comb begin
    cnt_nxt          = cnt_r;
    opener_ok_nxt    = opener_ok_r;
    closer_found_nxt = closer_found_r;
    closer_pos_nxt   = closer_pos_r;
    prev_byte_nxt    = prev_byte_r;
    mark_prog_nxt    = mark_prog_r;
    mark_found_nxt   = mark_found_r;
    mark_pos_nxt     = mark_pos_r;
    trace_hi_nxt     = trace_hi_r;
    trace_lo_nxt     = trace_lo_r;
    parent_nxt       = parent_r;
    flags_nxt        = flags_r;
    fvalid_nxt       = fvalid_r;
    if (take) begin
      // comment opener
      if (cnt_r == '0 && c != CH_SLASH) opener_ok_nxt = 1'b0;
      if (cnt_r == POS_W'(1) && c != CH_STAR) opener_ok_nxt = 1'b0;
      // first closer
      if (!closer_found_r && cnt_r != '0 && prev_byte_r == CH_STAR && c == CH_SLASH) begin
        closer_found_nxt = 1'b1;
        closer_pos_nxt   = cnt_r - POS_W'(1);
      end
      if (mark_found_r) begin
        // value fields
        if ({1'b0, cnt_r} >= val_start) begin
          if (rel == (POS_W+1)'(DASH_A_OFS)) begin
            if (c != CH_DASH) fvalid_nxt[FV_DASH_A] = 1'b0;
          end else if (rel == (POS_W+1)'(DASH_B_OFS)) begin
            if (c != CH_DASH) fvalid_nxt[FV_DASH_B] = 1'b0;
          end else if (rel == (POS_W+1)'(DASH_C_OFS)) begin
            if (c != CH_DASH) fvalid_nxt[FV_DASH_C] = 1'b0;
          end else if (rel >= (POS_W+1)'(TRACE_FIRST) && rel <= (POS_W+1)'(TRACE_LAST)) begin
            if (hex[4]) fvalid_nxt[FV_TRACE] = 1'b0;
            else if (!rel_m3[4]) trace_hi_nxt = {trace_hi_r[59:0], hex[3:0]};
            else trace_lo_nxt = {trace_lo_r[59:0], hex[3:0]};
          end else if (rel >= (POS_W+1)'(PARENT_FIRST) && rel <= (POS_W+1)'(PARENT_LAST)) begin
            if (hex[4]) fvalid_nxt[FV_PARENT] = 1'b0;
            else parent_nxt = {parent_r[59:0], hex[3:0]};
          end else if (rel >= (POS_W+1)'(FLAGS_FIRST) && rel <= (POS_W+1)'(FLAGS_LAST)) begin
            if (hex[4]) fvalid_nxt[FV_FLAGS] = 1'b0;
            else flags_nxt = {flags_r[3:0], hex[3:0]};
          end
        end
      end else begin
        // marker search
        if (k_new >= 4'(MARK_LEN)) begin
          mark_found_nxt = 1'b1;
          mark_pos_nxt   = cnt_r - POS_W'(MARK_LEN - 1);
          mark_prog_nxt  = 4'd0;
        end else begin
          mark_prog_nxt = k_new;
        end
      end
      prev_byte_nxt = c;
      cnt_nxt       = cnt_r + POS_W'(1);
    end
  end

  // Result evaluation from the updated state
  always_comb begin
    if (item.parameter_form) begin
      ok      = 1'b1;
      end_pos = cnt_nxt;
    end else begin
      ok      = opener_ok_nxt && (cnt_nxt >= POS_W'(2)) && closer_found_nxt;
      end_pos = closer_pos_nxt;
    end
    ok = ok && mark_found_nxt
         && ({1'b0, end_pos} >= ({1'b0, mark_pos_nxt} + (POS_W+1)'(MIN_SPAN)))
         && fvalid_nxt[FV_DASH_A] && fvalid_nxt[FV_DASH_B] && fvalid_nxt[FV_DASH_C];
    result = '0;
    if (ok && fvalid_nxt[FV_TRACE]) begin
      result.parse_status  = STAT_TRACE;
      result.trace_id_high = trace_hi_nxt;
      result.trace_id_low  = trace_lo_nxt;
      if (fvalid_nxt[FV_PARENT]) begin
        result.parse_status   = STAT_PARENT;
        result.parent_span_id = parent_nxt;
        if (fvalid_nxt[FV_FLAGS]) begin
          result.parse_status  = STAT_ALL;
          result.sampled_flags = flags_nxt;
        end
      end
    end
  end

  // State registers; the last byte returns everything to the idle state
  always_ff @(posedge clk) begin
    if (!rst_n || (adv && item.last_byte)) begin
      cnt_r          <= '0;
      opener_ok_r    <= 1'b1;
      closer_found_r <= 1'b0;
      closer_pos_r   <= '0;
      prev_byte_r    <= '0;
      mark_prog_r    <= '0;
      mark_found_r   <= 1'b0;
      mark_pos_r     <= '0;
      trace_hi_r     <= '0;
      trace_lo_r     <= '0;
      parent_r       <= '0;
      flags_r        <= '0;
      fvalid_r       <= '1;
    end else if (adv) begin
      cnt_r          <= cnt_nxt;
      opener_ok_r    <= opener_ok_nxt;
      closer_found_r <= closer_found_nxt;
      closer_pos_r   <= closer_pos_nxt;
      prev_byte_r    <= prev_byte_nxt;
      mark_prog_r    <= mark_prog_nxt;
      mark_found_r   <= mark_found_nxt;
      mark_pos_r     <= mark_pos_nxt;
      trace_hi_r     <= trace_hi_nxt;
      trace_lo_r     <= trace_lo_nxt;
      parent_r       <= parent_nxt;
      flags_r        <= flags_nxt;
      fvalid_r       <= fvalid_nxt;
    end
  end

  // Checks
  a_prog_range: assert property (@(posedge clk) disable iff (!rst_n)
    mark_prog_r < 4'(MARK_LEN))
    else $error("marker progress out of range");

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cnt_r} <= (POS_W+1)'(MAX_TEXT))
    else $error("byte count past limit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item.last_byte |=> cnt_r == '0 && fvalid_r == 6'h3F && !mark_found_r)
    else $error("scanner state not cleared after last byte");

  a_marker_held: assert property (@(posedge clk) disable iff (!rst_n)
    mark_found_r && !(adv && item.last_byte) |=> mark_found_r && $stable(mark_pos_r))
    else $error("marker position changed mid-text");

endmodule

[rtl/core/traceparent_comment_parser_unit.sv]
// ----------------------------------------------------------------------------
// traceparent_comment_parser_unit: streaming traceparent extractor
// Takes text one byte per input transfer on in_valid/in_ready; in_last_byte
// ends a text and in_parameter_form (sampled with that byte) selects bare
// parameter text instead of a /* ... */ comment. Each text yields exactly
// one result transfer on out_valid/out_ready: parse status, 128-bit trace
// id, parent span id and flags, with unparsed fields zero.
// Throughput: one byte per cycle while in_ready is high; the scanner update is
// a single pass of compare and shift logic between the input register and
// scanner state. A last byte's result is loaded into the output register,
// which drives out_valid. A stalled result is held there; bytes that are not
// last keep flowing, and a following last byte waits in the input register
// until the output register frees, so in_ready drops only in that case.
// Reset (rst_n low, synchronous) empties both registers and clears the
// scanner, so the next byte starts a new text.
// ----------------------------------------------------------------------------
module traceparent_comment_parser_unit #(
  parameter longint unsigned MAX_TEXT = trcp_pkg::MAX_TEXT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_last_byte,
  input  logic        in_parameter_form,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_parse_status,
  output logic [63:0] out_trace_id_high,
  output logic [63:0] out_trace_id_low,
  output logic [63:0] out_parent_span_id,
  output logic [7:0]  out_sampled_flags
);
  import trcp_pkg::*;

  logic         s1_valid_r, s1_valid_nxt;
  trcp_item_t   s1_item_r;
  logic         out_valid_r, out_valid_nxt;
  trcp_result_t out_res_r;
  trcp_result_t scan_res;
  logic         s1_adv;
  logic         in_xfer;
  logic         res_load;

  // Stage handshake
  assign s1_adv   = s1_valid_r && (!s1_item_r.last_byte || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;
  assign res_load = s1_adv && s1_item_r.last_byte;

  assign s1_valid_nxt  = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = res_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Scanner
  trcp_scan #(
    .MAX_TEXT (MAX_TEXT)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (s1_adv),
    .item   (s1_item_r),
    .result (scan_res)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.text_byte      <= in_text_byte;
      s1_item_r.last_byte      <= in_last_byte;
      s1_item_r.parameter_form <= in_parameter_form;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= scan_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_parse_status   = out_res_r.parse_status;
  assign out_trace_id_high  = out_res_r.trace_id_high;
  assign out_trace_id_low   = out_res_r.trace_id_low;
  assign out_parent_span_id = out_res_r.parent_span_id;
  assign out_sampled_flags  = out_res_r.sampled_flags;

  // Checks
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> out_valid_r)
    else $error("last byte retired without a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> !out_valid_r || out_ready)
    else $error("result register overwritten while full");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_parse_status == STAT_NONE |->
      out_trace_id_high == '0 && out_trace_id_low == '0)
    else $error("trace id nonzero with empty status");

  a_partial_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_parse_status != STAT_ALL |-> out_sampled_flags == '0)
    else $error("flags nonzero without full parse");

endmodule

[bench/traceparent_comment_parser_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// traceparent_comment_parser_unit_test: self-checking bench for the parser
// Streams text bytes into the parser: a table of hand-made texts first, then
// random comment and parameter texts, mostly well-formed traceparent values
// with random digits and occasional damage, mixed with short noise texts.
// Results are predicted byte by byte or typed in, then compared field by field.
// The sender runs in bursts, the receiver stalls in phases and holds off
// once for a long stretch so the parser fills up and stops taking bytes.
// ----------------------------------------------------------------------------
module traceparent_comment_parser_unit_test;
  import trcp_pkg::*;

  localparam int unsigned TEXT_CAP = 32'(MAX_TEXT_DEF);
  localparam string MARKER = "traceparent='";
  localparam string TRC_F   = "ffffffffffffffffffffffffffffffff";
  localparam string PAR_F   = "ffffffffffffffff";
  localparam string TRC_Z   = "00000000000000000000000000000000";
  localparam string PAR_Z   = "0000000000000000";
  localparam string TRC_MIX = "0123456789abcdefABCDEF9876543210";
  localparam string PAR_MIX = "FEDCBA9876543210";
  localparam string NOISE_CHARS = "-*/t'0Fg= ";

  localparam int N_DIR            = 18;
  // random byte budget on top of the table, for about 1450 bytes in all
  localparam int RANDOM_ITEMS     = 270;
  localparam int HOLD_AFTER       = 6;
  localparam int HOLD_CYCLES      = 400;
  localparam int STALL_LIMIT      = 4000;
  localparam int DRAIN_CYCLES     = 8;

  localparam trcp_result_t RES_NONE     = '0;
  localparam trcp_result_t RES_ALL_ONES = {STAT_ALL, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, 8'hFF};
  localparam trcp_result_t RES_ALL_ZERO = {STAT_ALL, 200'd0};

  typedef enum {RDY_ALWAYS, RDY_HALF, RDY_SPARSE} ready_mode_t;

  // One directed text; "~" in body stands for a zero byte
  typedef struct {
    string        body;
    bit           bare;
    int           pad_to;
    bit           typed;
    trcp_result_t want;
  } dir_row_t;

  // Per-text note: typed-in result or predicted one
  typedef struct {
    bit           typed;
    trcp_result_t want;
  } text_tag_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_text_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        in_parameter_form = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_parse_status;
  logic [63:0] out_trace_id_high;
  logic [63:0] out_trace_id_low;
  logic [63:0] out_parent_span_id;
  logic [7:0]  out_sampled_flags;

  traceparent_comment_parser_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_text_byte      (in_text_byte),
    .in_last_byte      (in_last_byte),
    .in_parameter_form (in_parameter_form),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_parse_status  (out_parse_status),
    .out_trace_id_high (out_trace_id_high),
    .out_trace_id_low  (out_trace_id_low),
    .out_parent_span_id(out_parent_span_id),
    .out_sampled_flags (out_sampled_flags)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Bookkeeping
  trcp_result_t expected_q[$];
  text_tag_t    text_tag_q[$];
  logic [7:0]   text_buf[$];
  dir_row_t     dir_rows[N_DIR];
  int           fail_count = 0;
  int           results_seen = 0;
  int           idle_cycles = 0;
  int           burst_left = 0;

  // --------------------------------------------------------------------------
  // Scanner prediction state
  // --------------------------------------------------------------------------
  int unsigned scan_count;
  bit          opener_good;
  bit          closer_seen;
  int unsigned closer_at;
  logic [7:0]  prior_char;
  int unsigned match_len;
  bit          marker_seen;
  int unsigned marker_at;
  logic [63:0] trace_hi_acc;
  logic [63:0] trace_lo_acc;
  logic [63:0] parent_acc;
  logic [7:0]  flags_acc;
  logic [5:0]  field_ok;

  function automatic void clear_scan();
    scan_count   = 0;
    opener_good  = 1'b1;
    closer_seen  = 1'b0;
    closer_at    = 0;
    prior_char   = 8'h00;
    match_len    = 0;
    marker_seen  = 1'b0;
    marker_at    = 0;
    trace_hi_acc = '0;
    trace_lo_acc = '0;
    parent_acc   = '0;
    flags_acc    = '0;
    field_ok     = '1;
  endfunction

  // Hex value in [3:0]; bit 4 flags a non-digit
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 10)};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 10)};
    return 5'h10;
  endfunction

  // Restart point after a mismatch at marker position k
  function automatic int unsigned border_of(input int unsigned k);
    return (k == 11) ? 1 : 0;
  endfunction

  // One byte of the value, rel counted from just past the marker
  function automatic void take_value(input int unsigned rel, input logic [7:0] c);
    logic [4:0] h;
    h = nibble_of(c);
    if (rel == DASH_A_OFS) begin
      if (c != CH_DASH) field_ok[FV_DASH_A] = 1'b0;
    end else if (rel == DASH_B_OFS) begin
      if (c != CH_DASH) field_ok[FV_DASH_B] = 1'b0;
    end else if (rel == DASH_C_OFS) begin
      if (c != CH_DASH) field_ok[FV_DASH_C] = 1'b0;
    end else if (rel >= TRACE_FIRST && rel <= TRACE_LAST) begin
      if (h[4]) field_ok[FV_TRACE] = 1'b0;
      else if (rel - TRACE_FIRST < 16) trace_hi_acc = {trace_hi_acc[59:0], h[3:0]};
      else trace_lo_acc = {trace_lo_acc[59:0], h[3:0]};
    end else if (rel >= PARENT_FIRST && rel <= PARENT_LAST) begin
      if (h[4]) field_ok[FV_PARENT] = 1'b0;
      else parent_acc = {parent_acc[59:0], h[3:0]};
    end else if (rel >= FLAGS_FIRST && rel <= FLAGS_LAST) begin
      if (h[4]) field_ok[FV_FLAGS] = 1'b0;
      else flags_acc = {flags_acc[3:0], h[3:0]};
    end
  endfunction

  // Opener, closer, marker and value-field tracking for one byte inside the length cap
  function automatic void absorb_char(input logic [7:0] c);
    int unsigned k;
    if (scan_count == 0 && c != CH_SLASH) opener_good = 1'b0;
    if (scan_count == 1 && c != CH_STAR) opener_good = 1'b0;
    if (!closer_seen && scan_count >= 1 && prior_char == CH_STAR && c == CH_SLASH) begin
      closer_seen = 1'b1;
      closer_at   = scan_count - 1;
    end
    if (marker_seen) begin
      if (scan_count >= marker_at + MARK_LEN)
        take_value(scan_count - marker_at - MARK_LEN, c);
    end else begin
      k = match_len;
      while (k > 0 && c != MARKER[k]) k = border_of(k);
      if (c == MARKER[k]) k++;
      if (k == MARK_LEN) begin
        marker_seen = 1'b1;
        marker_at   = scan_count + 1 - MARK_LEN;
        k           = 0;
      end
      match_len = k;
    end
    prior_char = c;
  endfunction

  // Result of a finished text; clears the scanner for the next one
  function automatic trcp_result_t close_text(input bit bare);
    bit           ok;
    int unsigned  end_at;
    trcp_result_t res;
    if (bare) begin
      ok     = 1'b1;
      end_at = scan_count;
    end else begin
      ok     = opener_good && scan_count >= 2 && closer_seen;
      end_at = closer_at;
    end
    ok = ok && marker_seen && end_at >= marker_at && (end_at - marker_at) >= MIN_SPAN;
    ok = ok && field_ok[FV_DASH_A] && field_ok[FV_DASH_B] && field_ok[FV_DASH_C];
    res = '0;
    if (ok && field_ok[FV_TRACE]) begin
      res.parse_status  = STAT_TRACE;
      res.trace_id_high = trace_hi_acc;
      res.trace_id_low  = trace_lo_acc;
      if (field_ok[FV_PARENT]) begin
        res.parse_status   = STAT_PARENT;
        res.parent_span_id = parent_acc;
        if (field_ok[FV_FLAGS]) begin
          res.parse_status  = STAT_ALL;
          res.sampled_flags = flags_acc;
        end
      end
    end
    clear_scan();
    return res;
  endfunction

  initial clear_scan();

  // --------------------------------------------------------------------------
  // Input side: predict on every accepted byte
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    trcp_result_t predicted;
    text_tag_t    tag;
    if (rst_n && in_valid && in_ready) begin
      if (scan_count < TEXT_CAP) begin
        absorb_char(in_text_byte);
        scan_count++;
      end
      if (in_last_byte) begin
        predicted = close_text(in_parameter_form);
        tag = text_tag_q.pop_front();
        expected_q.push_back(tag.typed ? tag.want : predicted);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output side: compare each result transfer with the oldest expectation
  // --------------------------------------------------------------------------
  function automatic void check_field(input string fname, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, actual %h", fname, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    trcp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result transfer with no expectation pending");
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("parse_status", 64'(want.parse_status), 64'(out_parse_status));
        check_field("trace_id_high", want.trace_id_high, out_trace_id_high);
        check_field("trace_id_low", want.trace_id_low, out_trace_id_low);
        check_field("parent_span_id", want.parent_span_id, out_parent_span_id);
        check_field("sampled_flags", 64'(want.sampled_flags), 64'(out_sampled_flags));
      end
    end
  end

  // Watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: stall phases plus one long hold-off
  // --------------------------------------------------------------------------
  initial begin : receiver
    ready_mode_t mode;
    int          mode_left;
    bit          held_once;
    mode      = RDY_ALWAYS;
    mode_left = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_once && results_seen >= HOLD_AFTER) begin
        held_once = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = ready_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        RDY_ALWAYS: out_ready <= 1'b1;
        RDY_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
        default:    out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Offer one byte and wait for its transfer, then maybe pause
  task automatic send_byte(input logic [7:0] c, input bit last, input bit bare);
    in_valid          <= 1'b1;
    in_text_byte      <= c;
    in_last_byte      <= last;
    in_parameter_form <= bare;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 20);
    end
  endtask

  // Send text_buf as one text; mode flag is random except on the last byte
  task automatic send_text(input bit bare, input bit typed, input trcp_result_t want);
    text_tag_t tag;
    int        last_idx;
    tag.typed = typed;
    tag.want  = want;
    text_tag_q.push_back(tag);
    last_idx = text_buf.size() - 1;
    for (int i = 0; i <= last_idx; i++)
      send_byte(text_buf[i], i == last_idx, (i == last_idx) ? bare : 1'($urandom_range(0, 1)));
  endtask

  function automatic void put_byte(input logic [7:0] c);
    text_buf.push_back(c);
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte((s[i] == "~") ? 8'h00 : s[i]);
  endfunction

  // Random hex digits in random case
  function automatic void put_hex(input int n);
    int h;
    repeat (n) begin
      h = $urandom_range(0, 15);
      if (h < 10) put_byte(8'("0" + h));
      else if ($urandom_range(0, 1) == 1) put_byte(8'("a" + h - 10));
      else put_byte(8'("A" + h - 10));
    end
  endfunction

  function automatic logic [7:0] noise_char();
    if ($urandom_range(0, 1) == 1) return 8'($urandom_range(0, 255));
    return NOISE_CHARS[$urandom_range(0, NOISE_CHARS.len() - 1)];
  endfunction

  // Random text: mostly well-formed values with random damage, else noise
  function automatic void build_random_text(output bit bare);
    int kind;
    int start;
    text_buf.delete();
    bare = 1'($urandom_range(0, 1));
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      if (!bare) begin
        put_byte(($urandom_range(0, 19) == 0) ? noise_char() : CH_SLASH);
        put_byte(($urandom_range(0, 19) == 0) ? noise_char() : CH_STAR);
      end
      repeat ($urandom_range(0, 6)) put_byte(noise_char());
      if ($urandom_range(0, 3) == 0) put_str(MARKER.substr(0, $urandom_range(0, MARK_LEN - 2)));
      if (!bare && $urandom_range(0, 19) == 0) put_str("*/");
      put_str(MARKER);
      start = text_buf.size();
      put_hex(2);
      put_byte(CH_DASH);
      put_hex(32);
      put_byte(CH_DASH);
      put_hex(16);
      put_byte(CH_DASH);
      put_hex(2);
      if ($urandom_range(0, 3) == 0) text_buf[start + $urandom_range(0, 54)] = noise_char();
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 3)) void'(text_buf.pop_back());
      if ($urandom_range(0, 1) == 1) put_byte(8'h27);
      if (!bare && $urandom_range(0, 9) != 0) put_str("*/");
      repeat ($urandom_range(0, 4)) put_byte(noise_char());
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 12)) put_byte(noise_char());
    end else begin
      case ($urandom_range(0, 3))
        0:       put_str("/*");
        1:       put_str("*/");
        2:       put_str("/");
        default: put_byte(noise_char());
      endcase
    end
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit rand_bare;
    int random_bytes;
    random_bytes = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_rows = '{
      // too short for the opener, then opener alone
      '{"/", 1'b0, 0, 1'b1, RES_NONE},
      '{"/*", 1'b0, 0, 1'b1, RES_NONE},
      // all-ones and all-zeros values
      '{{"/*", MARKER, "00-", TRC_F, "-", PAR_F, "-ff'*/"}, 1'b0, 0, 1'b1, RES_ALL_ONES},
      '{{"/*", MARKER, "00-", TRC_Z, "-", PAR_Z, "-00'*/"}, 1'b0, 0, 1'b1, RES_ALL_ZERO},
      // parameter text ending right at the minimum span, then one short
      '{{MARKER, "01-", TRC_MIX, "-", PAR_MIX, "-0A"}, 1'b1, 0, 1'b0, RES_NONE},
      '{{MARKER, "01-", TRC_MIX, "-", PAR_MIX, "-0"}, 1'b1, 0, 1'b1, RES_NONE},
      // closer flush against the flags
      '{{"/*", MARKER, "ff-", TRC_MIX, "-", PAR_MIX, "-c3*/"}, 1'b0, 0, 1'b0, RES_NONE},
      // each dash wrong in turn
      '{{"/*", MARKER, "00_", TRC_F, "-", PAR_F, "-ff'*/"}, 1'b0, 0, 1'b1, RES_NONE},
      '{{"/*", MARKER, "00-", TRC_F, "+", PAR_F, "-ff'*/"}, 1'b0, 0, 1'b1, RES_NONE},
      '{{"/*", MARKER, "00-", TRC_F, "-", PAR_F, "=ff'*/"}, 1'b0, 0, 1'b1, RES_NONE},
      // bad flags digit, space in parent, sign in trace id
      '{{"/*", MARKER, "00-", TRC_MIX, "-", PAR_MIX, "-0x'*/"}, 1'b0, 0, 1'b0, RES_NONE},
      '{{"/*", MARKER, "00-", TRC_MIX, "-", " 123456789ABCDEF", "-01'*/"},
        1'b0, 0, 1'b0, RES_NONE},
      '{{"/*", MARKER, "00-", "+123456789abcdef0123456789abcdef", "-", PAR_MIX, "-01'*/"},
        1'b0, 0, 1'b1, RES_NONE},
      // missing opener: fatal in a comment, fine as a parameter
      '{{"-*", MARKER, "00-", TRC_MIX, "-", PAR_MIX, "-01'*/"}, 1'b0, 0, 1'b1, RES_NONE},
      '{{"-*", MARKER, "00-", TRC_MIX, "-", PAR_MIX, "-01'*/"}, 1'b1, 0, 1'b0, RES_NONE},
      // no closer; closer ahead of the marker
      '{{"/*", MARKER, "00-", TRC_MIX, "-", PAR_MIX, "-01'"}, 1'b0, 0, 1'b1, RES_NONE},
      '{{"/**/", MARKER, "00-", TRC_MIX, "-", PAR_MIX, "-01'*/"}, 1'b0, 0, 1'b1, RES_NONE},
      // zero bytes, partial markers that fall back, zero byte as a flag digit
      '{{"~~traceparenttraceparent=", MARKER, "00-", TRC_MIX, "-", PAR_MIX, "-~1"},
        1'b1, 0, 1'b0, RES_NONE}
    };

    foreach (dir_rows[i]) begin
      text_buf.delete();
      put_str(dir_rows[i].body);
      while (text_buf.size() < dir_rows[i].pad_to) put_byte("x");
      send_text(dir_rows[i].bare, dir_rows[i].typed, dir_rows[i].want);
    end

    while (random_bytes < RANDOM_ITEMS) begin
      build_random_text(rand_bare);
      random_bytes += text_buf.size();
      send_text(rand_bare, 1'b0, RES_NONE);
    end
    in_valid <= 1'b0;

    // drain outstanding results
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
